// ===== src/button_debounce_hold_repeat_defines.svh =====
// Assertion macros shared by the button debounce RTL.
`ifndef BUTTON_DEBOUNCE_HOLD_REPEAT_DEFINES_SVH
`define BUTTON_DEBOUNCE_HOLD_REPEAT_DEFINES_SVH

`ifndef SYNTHESIS

// Check that a property holds at every clock edge outside reset.
`define BDHR_ASSERT(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("bdhr assertion failed");

// Check that a condition never occurs outside reset.
`define BDHR_ASSERT_NEVER(label, clk, rst, cond) \
   label: assert property (@(posedge clk) disable iff (rst) !(cond)) \
      else $error("bdhr forbidden condition seen");

`else

`define BDHR_ASSERT(label, clk, rst, prop)

`define BDHR_ASSERT_NEVER(label, clk, rst, cond)

`endif

`endif

// ===== src/bdhr_pkg.sv =====
// Shared types and constants of the button debounce, hold and repeat block.
package bdhr_pkg;

   localparam int BUTTONS = 5;
   localparam int TIME_W  = 32;
   localparam int CFG_W   = 16;
   localparam int ADDR_W  = 4;
   localparam int DATA_W  = 32;

   localparam logic [CFG_W-1:0] DEBOUNCE_RESET     = 16'd30;
   localparam logic [CFG_W-1:0] LONG_PRESS_RESET   = 16'd1000;
   localparam logic [CFG_W-1:0] REPEAT_DELAY_RESET = 16'd500;
   localparam logic [CFG_W-1:0] REPEAT_PERIOD_RESET = 16'd100;

   typedef enum logic [1:0] {
      REG_DEBOUNCE_TIME   = 2'd0,
      REG_LONG_PRESS_TIME = 2'd1,
      REG_REPEAT_DELAY    = 2'd2,
      REG_REPEAT_PERIOD   = 2'd3
   } reg_index_type;

   typedef struct packed {
      logic [BUTTONS-1:0] pin_levels;
      logic [TIME_W-1:0]  now_ms;
   } req_type;

   typedef struct packed {
      logic [BUTTONS-1:0] pressed_mask;
      logic [BUTTONS-1:0] press_edge_mask;
      logic [BUTTONS-1:0] release_edge_mask;
      logic [BUTTONS-1:0] held_mask;
      logic [BUTTONS-1:0] repeat_mask;
   } rsp_type;

   typedef struct packed {
      logic [CFG_W-1:0] debounce_time;
      logic [CFG_W-1:0] long_press_time;
      logic [CFG_W-1:0] repeat_delay;
      logic [CFG_W-1:0] repeat_period;
   } cfg_type;

   typedef struct packed {
      logic pressed;
      logic press_edge;
      logic release_edge;
      logic held;
      logic repeat_fire;
   } btn_flags_type;

endpackage

// ===== src/bdhr_csr.sv =====
// Configuration register file behind the APB-style port.
module bdhr_csr (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         psel,
   input  logic                         penable,
   input  logic                         pwrite,
   input  logic [bdhr_pkg::ADDR_W-1:0]  paddr,
   input  logic [bdhr_pkg::DATA_W-1:0]  pwdata,
   output logic [bdhr_pkg::DATA_W-1:0]  prdata,
   output logic                         pready,
   output bdhr_pkg::cfg_type            cfg
);
   import bdhr_pkg::*;

   cfg_type       cfg_ff;
   cfg_type       cfg_in;
   reg_index_type reg_index;
   logic          wr_en;
   logic [CFG_W-1:0] rd_value;

   assign pready    = 1'b1;
   assign reg_index = reg_index_type'(paddr[3:2]);
   assign wr_en     = psel & penable & pwrite & pready;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         unique case (reg_index)
            REG_DEBOUNCE_TIME:   cfg_in.debounce_time   = pwdata[CFG_W-1:0];
            REG_LONG_PRESS_TIME: cfg_in.long_press_time = pwdata[CFG_W-1:0];
            REG_REPEAT_DELAY:    cfg_in.repeat_delay    = pwdata[CFG_W-1:0];
            REG_REPEAT_PERIOD:   cfg_in.repeat_period   = pwdata[CFG_W-1:0];
            default:             cfg_in = cfg_ff;
         endcase
      end
   end

   always_comb begin
      unique case (reg_index)
         REG_DEBOUNCE_TIME:   rd_value = cfg_ff.debounce_time;
         REG_LONG_PRESS_TIME: rd_value = cfg_ff.long_press_time;
         REG_REPEAT_DELAY:    rd_value = cfg_ff.repeat_delay;
         REG_REPEAT_PERIOD:   rd_value = cfg_ff.repeat_period;
         default:             rd_value = '0;
      endcase
   end

   assign prdata = {{(DATA_W-CFG_W){1'b0}}, rd_value};
   assign cfg    = cfg_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.debounce_time   <= DEBOUNCE_RESET;
         cfg_ff.long_press_time <= LONG_PRESS_RESET;
         cfg_ff.repeat_delay    <= REPEAT_DELAY_RESET;
         cfg_ff.repeat_period   <= REPEAT_PERIOD_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

// ===== src/bdhr_button.sv =====
// Per-button debounce, edge, long-press and auto-repeat logic.
module bdhr_button (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         enable,
   input  logic                         raw_pressed,
   input  logic [bdhr_pkg::TIME_W-1:0]  now_ms,
   input  bdhr_pkg::cfg_type            cfg,
   output bdhr_pkg::btn_flags_type      flags
);
   import bdhr_pkg::*;

   logic              raw_seen_ff, raw_seen_in;
   logic              stable_ff, stable_in;
   logic              repeating_ff, repeating_in;
   logic [TIME_W-1:0] change_time_ff, change_time_in;
   logic [TIME_W-1:0] press_time_ff, press_time_in;
   logic [TIME_W-1:0] repeat_time_ff, repeat_time_in;

   logic              raw_change;
   logic [TIME_W-1:0] settle_elapsed;
   logic [TIME_W-1:0] held_elapsed;
   logic [TIME_W-1:0] repeat_elapsed;
   logic              press_edge, release_edge;
   logic              rep_active;
   logic              fire_first, fire_next;

   // A restarted timer or a fresh press always reads zero elapsed time, so
   // every compare works from the old state in parallel.
   assign raw_change     = raw_pressed != raw_seen_ff;
   assign raw_seen_in    = raw_pressed;
   assign change_time_in = raw_change ? now_ms : change_time_ff;
   assign settle_elapsed = raw_change ? '0 : now_ms - change_time_ff;
   assign stable_in      = (settle_elapsed >= TIME_W'(cfg.debounce_time)) ?
                           raw_pressed : stable_ff;

   assign press_edge   = stable_in & ~stable_ff;
   assign release_edge = ~stable_in & stable_ff;

   assign held_elapsed   = press_edge ? '0 : now_ms - press_time_ff;
   assign repeat_elapsed = press_edge ? '0 : now_ms - repeat_time_ff;
   assign rep_active     = (press_edge | release_edge) ? 1'b0 : repeating_ff;

   assign fire_first = stable_in & ~rep_active &
                       (held_elapsed >= TIME_W'(cfg.repeat_delay));
   assign fire_next  = stable_in & rep_active &
                       (repeat_elapsed >= TIME_W'(cfg.repeat_period));

   assign repeating_in   = fire_first | rep_active;
   assign press_time_in  = press_edge ? now_ms : press_time_ff;
   assign repeat_time_in = (press_edge | fire_first | fire_next) ? now_ms : repeat_time_ff;

   assign flags.pressed      = stable_in;
   assign flags.press_edge   = press_edge;
   assign flags.release_edge = release_edge;
   assign flags.held         = stable_in & (held_elapsed >= TIME_W'(cfg.long_press_time));
   assign flags.repeat_fire  = fire_first | fire_next;

   always_ff @(posedge clock) begin
      if (reset) begin
         raw_seen_ff    <= 1'b0;
         stable_ff      <= 1'b0;
         repeating_ff   <= 1'b0;
         change_time_ff <= '0;
         press_time_ff  <= '0;
         repeat_time_ff <= '0;
      end else if (enable) begin
         raw_seen_ff    <= raw_seen_in;
         stable_ff      <= stable_in;
         repeating_ff   <= repeating_in;
         change_time_ff <= change_time_in;
         press_time_ff  <= press_time_in;
         repeat_time_ff <= repeat_time_in;
      end
   end

endmodule

// ===== src/button_debounce_hold_repeat.sv =====
// Top level of the five-button debouncer with long press and auto repeat.
//
//  channel | direction | handshake            | payload
//  --------+-----------+----------------------+-------------------------------
//  req     | in        | req_valid/req_ready  | req_item: pin_levels, now_ms
//  rsp     | out       | rsp_valid/rsp_ready  | rsp_item: five button masks
//  csr     | in/out    | psel/penable/pready  | four 16-bit timing registers
//
//  One update per cycle while results are taken: a transfer lands in the input
//  register, is worked combinationally by the per-button logic and lands in
//  the result register.
//  The result register is the only stall point: while it holds an untaken
//  result, the input register holds its item and req_ready drops once full.
//  Reset is synchronous; it restores register defaults and clears all
//  button state to not pressed with zero timestamps.
module button_debounce_hold_repeat (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_ready,
   input  bdhr_pkg::req_type            req_item,
   output logic                         rsp_valid,
   input  logic                         rsp_ready,
   output bdhr_pkg::rsp_type            rsp_item,
   input  logic                         psel,
   input  logic                         penable,
   input  logic                         pwrite,
   input  logic [bdhr_pkg::ADDR_W-1:0]  paddr,
   input  logic [bdhr_pkg::DATA_W-1:0]  pwdata,
   output logic [bdhr_pkg::DATA_W-1:0]  prdata,
   output logic                         pready
);
   import bdhr_pkg::*;
`include "button_debounce_hold_repeat_defines.svh"

   cfg_type       cfg;
   req_type       in_ff;
   logic          in_valid_ff;
   rsp_type       rsp_ff, rsp_in;
   logic          rsp_valid_ff;
   logic          advance;
   btn_flags_type flags [BUTTONS];

   // Advance the input item whenever the result register is empty or drains.
   assign advance   = in_valid_ff & (~rsp_valid_ff | rsp_ready);
   assign req_ready = ~in_valid_ff | advance;

   bdhr_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   // One lane per button; pins are active low.
   for (genvar i = 0; i < BUTTONS; i++) begin : g_button
      bdhr_button u_button (
         .clock       (clock),
         .reset       (reset),
         .enable      (advance),
         .raw_pressed (~in_ff.pin_levels[i]),
         .now_ms      (in_ff.now_ms),
         .cfg         (cfg),
         .flags       (flags[i])
      );

      assign rsp_in.pressed_mask[i]      = flags[i].pressed;
      assign rsp_in.press_edge_mask[i]   = flags[i].press_edge;
      assign rsp_in.release_edge_mask[i] = flags[i].release_edge;
      assign rsp_in.held_mask[i]         = flags[i].held;
      assign rsp_in.repeat_mask[i]       = flags[i].repeat_fire;
   end

   // Capture a new item on transfer; hold the payload otherwise.
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (req_ready) begin
            in_valid_ff <= req_valid;
         end
         if (advance) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_ready & req_valid) begin
         in_ff <= req_item;
      end
      if (advance) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_ff;

   `BDHR_ASSERT(a_stall_only_when_full, clock, reset, !req_ready |-> in_valid_ff)
   `BDHR_ASSERT(a_advance_loads_result, clock, reset, advance |=> rsp_valid_ff)
   `BDHR_ASSERT_NEVER(a_edges_disjoint, clock, reset, rsp_valid_ff && ((rsp_ff.press_edge_mask & rsp_ff.release_edge_mask) != '0))
   `BDHR_ASSERT_NEVER(a_press_edge_pressed, clock, reset, rsp_valid_ff && ((rsp_ff.press_edge_mask & ~rsp_ff.pressed_mask) != '0))
   `BDHR_ASSERT_NEVER(a_release_edge_released, clock, reset, rsp_valid_ff && ((rsp_ff.release_edge_mask & rsp_ff.pressed_mask) != '0))
   `BDHR_ASSERT_NEVER(a_hold_repeat_pressed, clock, reset, rsp_valid_ff && (((rsp_ff.held_mask | rsp_ff.repeat_mask) & ~rsp_ff.pressed_mask) != '0))

endmodule

// ===== sim/debounce_checker.sv =====
// Checker that predicts the button masks of every update, compares each result transfer and checks register reads.
module debounce_checker (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   input  logic                         req_ready,
   input  bdhr_pkg::req_type            req_item,
   input  logic                         rsp_valid,
   input  logic                         rsp_ready,
   input  bdhr_pkg::rsp_type            rsp_item,
   input  logic                         psel,
   input  logic                         penable,
   input  logic                         pwrite,
   input  logic [bdhr_pkg::ADDR_W-1:0]  paddr,
   input  logic [bdhr_pkg::DATA_W-1:0]  pwdata,
   input  logic [bdhr_pkg::DATA_W-1:0]  prdata,
   input  logic                         pready,
   output int                           error_count,
   output int                           pending_count
);
   import bdhr_pkg::*;

   cfg_type            timing;
   logic [BUTTONS-1:0] raw_seen;
   logic [BUTTONS-1:0] stable_now;
   logic [BUTTONS-1:0] stable_last;
   logic [BUTTONS-1:0] repeating;
   logic [TIME_W-1:0]  change_ms [BUTTONS];
   logic [TIME_W-1:0]  press_ms  [BUTTONS];
   logic [TIME_W-1:0]  repeat_ms [BUTTONS];
   rsp_type            expected_masks [$];
   rsp_type            want;
   reg_index_type      reg_sel;
   logic [CFG_W-1:0]   reg_value;

   // Advance every button by one update and return the masks it yields.
   function automatic rsp_type debounce_update(input req_type upd);
      rsp_type           masks;
      logic              raw;
      logic [TIME_W-1:0] held_ms;
      logic [TIME_W-1:0] elapsed_ms;
      masks = '0;
      for (int b = 0; b < BUTTONS; b++) begin
         raw = ~upd.pin_levels[b];
         if (raw != raw_seen[b]) begin
            raw_seen[b]  = raw;
            change_ms[b] = upd.now_ms;
         end
         stable_last[b] = stable_now[b];
         elapsed_ms = upd.now_ms - change_ms[b];
         if (elapsed_ms >= TIME_W'(timing.debounce_time)) stable_now[b] = raw_seen[b];

         if (stable_now[b] && !stable_last[b]) begin
            press_ms[b]  = upd.now_ms;
            repeating[b] = 1'b0;
            repeat_ms[b] = upd.now_ms;
            masks.press_edge_mask[b] = 1'b1;
         end
         if (!stable_now[b] && stable_last[b]) begin
            repeating[b] = 1'b0;
            masks.release_edge_mask[b] = 1'b1;
         end

         if (stable_now[b]) begin
            held_ms = upd.now_ms - press_ms[b];
            masks.pressed_mask[b] = 1'b1;
            if (held_ms >= TIME_W'(timing.long_press_time)) masks.held_mask[b] = 1'b1;
            elapsed_ms = upd.now_ms - repeat_ms[b];
            if (!repeating[b]) begin
               if (held_ms >= TIME_W'(timing.repeat_delay)) begin
                  repeating[b] = 1'b1;
                  repeat_ms[b] = upd.now_ms;
                  masks.repeat_mask[b] = 1'b1;
               end
            end else if (elapsed_ms >= TIME_W'(timing.repeat_period)) begin
               repeat_ms[b] = upd.now_ms;
               masks.repeat_mask[b] = 1'b1;
            end
         end
      end
      return masks;
   endfunction

   function automatic void check_mask(string field, logic [BUTTONS-1:0] exp_mask,
                                      logic [BUTTONS-1:0] got_mask);
      if (exp_mask !== got_mask) begin
         $error("%s: expected %b, got %b", field, exp_mask, got_mask);
         error_count++;
      end
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         timing = '{DEBOUNCE_RESET, LONG_PRESS_RESET, REPEAT_DELAY_RESET,
                    REPEAT_PERIOD_RESET};
         raw_seen    = '0;
         stable_now  = '0;
         stable_last = '0;
         repeating   = '0;
         for (int b = 0; b < BUTTONS; b++) begin
            change_ms[b] = '0;
            press_ms[b]  = '0;
            repeat_ms[b] = '0;
         end
         expected_masks.delete();
      end else begin
         // register access phase: track writes, check reads
         if (psel && penable && pready) begin
            reg_sel = reg_index_type'(paddr[3:2]);
            if (pwrite) begin
               case (reg_sel)
                  REG_DEBOUNCE_TIME:   timing.debounce_time   = pwdata[CFG_W-1:0];
                  REG_LONG_PRESS_TIME: timing.long_press_time = pwdata[CFG_W-1:0];
                  REG_REPEAT_DELAY:    timing.repeat_delay    = pwdata[CFG_W-1:0];
                  REG_REPEAT_PERIOD:   timing.repeat_period   = pwdata[CFG_W-1:0];
                  default: ;
               endcase
            end else begin
               case (reg_sel)
                  REG_DEBOUNCE_TIME:   reg_value = timing.debounce_time;
                  REG_LONG_PRESS_TIME: reg_value = timing.long_press_time;
                  REG_REPEAT_DELAY:    reg_value = timing.repeat_delay;
                  default:             reg_value = timing.repeat_period;
               endcase
               if (prdata[CFG_W-1:0] !== reg_value) begin
                  $error("prdata: expected %h, got %h", reg_value, prdata[CFG_W-1:0]);
                  error_count++;
               end
            end
         end

         if (req_valid && req_ready) expected_masks.push_back(debounce_update(req_item));

         if (rsp_valid && rsp_ready) begin
            if (expected_masks.size() == 0) begin
               $error("rsp_item: expected no result, got %h", rsp_item);
               error_count++;
            end else begin
               want = expected_masks.pop_front();
               check_mask("pressed_mask", want.pressed_mask, rsp_item.pressed_mask);
               check_mask("press_edge_mask", want.press_edge_mask, rsp_item.press_edge_mask);
               check_mask("release_edge_mask", want.release_edge_mask,
                          rsp_item.release_edge_mask);
               check_mask("held_mask", want.held_mask, rsp_item.held_mask);
               check_mask("repeat_mask", want.repeat_mask, rsp_item.repeat_mask);
            end
         end
      end
      pending_count = expected_masks.size();
   end

endmodule

// ===== sim/tb_button_debounce_hold_repeat.sv =====
// Testbench top: drives updates, result stalls and register traffic, and gives the verdict.
module tb_button_debounce_hold_repeat;
   import bdhr_pkg::*;

   // Traffic shapes: which side inserts idle cycles during a phase.
   typedef enum int {FLOW_FREE, FLOW_SEND_GAPS, FLOW_RECV_STALLS, FLOW_BOTH} flow_mode_type;
   // Register settings used by the random phases.
   typedef enum int {
      PROFILE_RESET, PROFILE_SHORT, PROFILE_ZERO_MIX, PROFILE_MAX, PROFILE_WIDE
   } timing_profile_type;

   localparam int STALL_LIMIT    = 2000;  // cycles without any transfer before giving up
   localparam int RANDOM_PHASES  = 10;
   localparam int PHASE_UPDATES  = 88;
   localparam int PROFILE_COUNT  = 5;
   localparam int FLOW_COUNT     = 4;
   localparam int SETTLE_CYCLES  = 4;     // wait before the verdict
   localparam int PAUSE_PHASE    = 2;     // phase in which the sender drains mid-way

   logic               clock     = 1'b0;
   logic               reset     = 1'b1;
   logic               req_valid = 1'b0;
   logic               req_ready;
   req_type            req_item  = '0;
   logic               rsp_valid;
   logic               rsp_ready = 1'b0;
   rsp_type            rsp_item;
   logic               psel      = 1'b0;
   logic               penable   = 1'b0;
   logic               pwrite    = 1'b0;
   logic [ADDR_W-1:0]  paddr     = '0;
   logic [DATA_W-1:0]  pwdata    = '0;
   logic [DATA_W-1:0]  prdata;
   logic               pready;

   int                 error_count;
   int                 pending_count;
   int                 quiet_cycles = 0;
   flow_mode_type      flow = FLOW_FREE;
   logic [TIME_W-1:0]  sim_ms = '0;   // running timestamp of the random phases

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   button_debounce_hold_repeat dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_item  (req_item),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_item  (rsp_item),
      .psel      (psel),
      .penable   (penable),
      .pwrite    (pwrite),
      .paddr     (paddr),
      .pwdata    (pwdata),
      .prdata    (prdata),
      .pready    (pready)
   );

   debounce_checker masks_check (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_item      (req_item),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_item      (rsp_item),
      .psel          (psel),
      .penable       (penable),
      .pwrite        (pwrite),
      .paddr         (paddr),
      .pwdata        (pwdata),
      .prdata        (prdata),
      .pready        (pready),
      .error_count   (error_count),
      .pending_count (pending_count)
   );

   // Result side: drop ready at random according to the current traffic shape.
   always @(negedge clock) begin
      case (flow)
         FLOW_RECV_STALLS: rsp_ready <= ($urandom_range(99) >= 70);
         FLOW_BOTH:        rsp_ready <= ($urandom_range(99) >= 34);
         default:          rsp_ready <= 1'b1;
      endcase
   end

   // Watchdog: count cycles in which neither channel moves a transfer.
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
      if (quiet_cycles >= STALL_LIMIT) begin
         $display("FAIL");
         $finish;
      end
   end

   // Decide whether the sender keeps idling before it presents the next update.
   function automatic bit sender_holds();
      case (flow)
         FLOW_SEND_GAPS: return $urandom_range(99) < 70;
         FLOW_BOTH:      return $urandom_range(99) < 34;
         default:        return 1'b0;
      endcase
   endfunction

   // Present one update and hold it until the transfer; returns at a falling edge
   // with valid still high so back-to-back updates keep valid asserted.
   task automatic send_update(input logic [BUTTONS-1:0] pins, input logic [TIME_W-1:0] stamp);
      while (sender_holds()) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_item  <= '{pin_levels: pins, now_ms: stamp};
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      @(negedge clock);
   endtask

   // Drop valid and wait until every predicted result has been taken.
   task automatic hold_until_drained();
      req_valid <= 1'b0;
      do @(negedge clock); while (pending_count != 0);
   endtask

   // One register transfer: setup cycle, then access cycle until pready.
   // Upper data bits are random; only the low 16 bits belong to the register.
   task automatic csr_access(input bit write_en, input reg_index_type idx,
                             input logic [CFG_W-1:0] value);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= write_en;
      paddr   <= {idx, 2'b00};
      pwdata  <= {16'($urandom), value};
      @(negedge clock);
      penable <= 1'b1;
      @(posedge clock);
      while (!pready) @(posedge clock);
      @(negedge clock);
      psel    <= 1'b0;
      penable <= 1'b0;
      @(negedge clock);
   endtask

   // Write all four timing registers, then read them back for the checker.
   task automatic program_timing(input cfg_type t);
      csr_access(1'b1, REG_DEBOUNCE_TIME,   t.debounce_time);
      csr_access(1'b1, REG_LONG_PRESS_TIME, t.long_press_time);
      csr_access(1'b1, REG_REPEAT_DELAY,    t.repeat_delay);
      csr_access(1'b1, REG_REPEAT_PERIOD,   t.repeat_period);
      csr_access(1'b0, REG_DEBOUNCE_TIME,   '0);
      csr_access(1'b0, REG_LONG_PRESS_TIME, '0);
      csr_access(1'b0, REG_REPEAT_DELAY,    '0);
      csr_access(1'b0, REG_REPEAT_PERIOD,   '0);
   endtask

   function automatic cfg_type pick_timing(input timing_profile_type profile);
      cfg_type t;
      case (profile)
         PROFILE_RESET: begin
            t = '{DEBOUNCE_RESET, LONG_PRESS_RESET, REPEAT_DELAY_RESET, REPEAT_PERIOD_RESET};
         end
         PROFILE_SHORT: begin
            t.debounce_time   = 16'($urandom_range(8));
            t.long_press_time = 16'($urandom_range(80));
            t.repeat_delay    = 16'($urandom_range(40));
            t.repeat_period   = 16'($urandom_range(12));
         end
         PROFILE_ZERO_MIX: begin
            // each register either zero or a few ms
            t.debounce_time   = $urandom_range(1) ? 16'd0 : 16'($urandom_range(20, 1));
            t.long_press_time = $urandom_range(1) ? 16'd0 : 16'($urandom_range(20, 1));
            t.repeat_delay    = $urandom_range(1) ? 16'd0 : 16'($urandom_range(20, 1));
            t.repeat_period   = $urandom_range(1) ? 16'd0 : 16'($urandom_range(20, 1));
         end
         PROFILE_MAX: begin
            t = '1;
         end
         default: begin
            t.debounce_time   = 16'($urandom);
            t.long_press_time = 16'($urandom);
            t.repeat_delay    = 16'($urandom);
            t.repeat_period   = 16'($urandom);
         end
      endcase
      return t;
   endfunction

   // Random phase: buttons hold a level for a while with occasional flips
   // (bounce when steps are short), time mostly advances, sometimes jumps.
   task automatic run_phase(input int phase, input int count);
      cfg_type            t;
      int                 peak;
      int                 span;
      int                 flip_odds;
      logic [BUTTONS-1:0] pins;
      t = pick_timing(timing_profile_type'(phase % PROFILE_COUNT));
      program_timing(t);
      flow = flow_mode_type'(phase % FLOW_COUNT);
      // scale time steps to the slowest register so thresholds get crossed
      peak = t.debounce_time;
      if (t.long_press_time > peak) peak = t.long_press_time;
      if (t.repeat_delay > peak) peak = t.repeat_delay;
      if (t.repeat_period > peak) peak = t.repeat_period;
      span      = peak / 3 + 2;
      flip_odds = $urandom_range(20, 4);
      pins      = '1;
      if ($urandom_range(3) == 0) sim_ms = $urandom;
      for (int n = 0; n < count; n++) begin
         for (int b = 0; b < BUTTONS; b++) begin
            if ($urandom_range(flip_odds - 1) == 0) pins[b] = ~pins[b];
         end
         case ($urandom_range(59))
            0:       sim_ms = $urandom;                       // arbitrary jump, often back
            1:       sim_ms = sim_ms - $urandom_range(span);  // short step back
            default: sim_ms = sim_ms + $urandom_range(span);
         endcase
         send_update(pins, sim_ms);
         // sender pause: let every pending result drain before going on
         if (phase == PAUSE_PHASE && n == count / 2) hold_until_drained();
      end
      hold_until_drained();
   endtask

   initial begin
      repeat (8) @(negedge clock);
      reset <= 1'b0;

      // Register defaults: debounce, press edge, first and later repeat, hold, release.
      send_update(5'h1F, 32'd0);
      send_update(5'h00, 32'd10);
      send_update(5'h00, 32'd40);
      send_update(5'h00, 32'd540);
      send_update(5'h00, 32'd640);
      send_update(5'h00, 32'd1040);
      send_update(5'h1F, 32'd1050);
      send_update(5'h1F, 32'd1080);
      hold_until_drained();

      // All zero: stable at once, repeat in the press update and every update after,
      // plus timestamp wrap and backward jumps.
      program_timing('0);
      send_update(5'h00, 32'd5);
      send_update(5'h00, 32'd5);
      send_update(5'h15, 32'hFFFF_FFFF);
      send_update(5'h0A, 32'h0000_0003);
      send_update(5'h1F, 32'hFFFF_FFF0);
      send_update(5'h00, 32'hFFFF_FFFF);
      hold_until_drained();

      // All maximum: thresholds hit exactly and one ms short.
      program_timing('1);
      send_update(5'h1F, 32'd0);
      send_update(5'h1F, 32'd65534);
      send_update(5'h1F, 32'd65535);
      send_update(5'h00, 32'd70000);
      send_update(5'h00, 32'd135535);
      send_update(5'h00, 32'd201070);
      send_update(5'h00, 32'd266604);
      send_update(5'h00, 32'd266605);
      hold_until_drained();

      for (int phase = 0; phase < RANDOM_PHASES; phase++) run_phase(phase, PHASE_UPDATES);

      hold_until_drained();
      repeat (SETTLE_CYCLES) @(negedge clock);
      if (error_count == 0 && pending_count == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

endmodule

// ===== sim.f =====
+incdir+src
src/bdhr_pkg.sv
src/bdhr_csr.sv
src/bdhr_button.sv
src/button_debounce_hold_repeat.sv
sim/debounce_checker.sv
sim/tb_button_debounce_hold_repeat.sv
